// ===== design/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the block matrix multiplier
// Field widths, configuration defaults, controller states and the command
// and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Payload field widths
  localparam int A_W   = 16;
  localparam int B_W   = 16;
  localparam int C_W   = 35;
  localparam int PROD_W = A_W + B_W;

  // Size register
  localparam int          CFG_W     = 4;
  localparam logic [3:0]  CFG_RESET = 4'd8;

  // Default for the top-level dimension parameter
  localparam int MAX_DIM_DEF = 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_FLUSH_A,
    ST_FLUSH_B,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_wr;    // store the incoming pair, bump load count
    logic run_start;  // clear indexes, accumulator and load count
    logic issue;      // read one A/B pair, step k
    logic next_elem;  // step to the next element of C
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_done;  // the pair being stored completes the run
    logic k_last;     // current k is the last term of the dot product
    logic elem_last;  // current element is the last of C
  } status_t;

endpackage

// ===== design/bmm_ram.sv =====
// ----------------------------------------------------------------------------
// bmm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== design/bmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmm_ctrl: sequencer for the block matrix multiplier
// Steps through loading, the multiply-accumulate walk per element of C,
// the pipeline flush and the result handshake.
// ----------------------------------------------------------------------------
module bmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bmm_pkg::status_t  status,
  output bmm_pkg::cmd_t     cmd
);

  import bmm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && status.load_done) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (status.k_last) begin
          state_nxt = ST_FLUSH_A;
        end
      end
      ST_FLUSH_A: state_nxt = ST_FLUSH_B;
      ST_FLUSH_B: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = status.elem_last ? ST_LOAD : ST_MAC;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.load_wr   = in_valid;
        cmd.run_start = in_valid && status.load_done;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
      end
      ST_FLUSH_A, ST_FLUSH_B: begin
      end
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.next_elem = out_ready && !status.elem_last;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/bmm_dp.sv =====
// ----------------------------------------------------------------------------
// bmm_dp: datapath of the block matrix multiplier
// Size register, load counter, A and B element stores, row/column/term
// indexes, a registered multiplier and the accumulator for one element of C.
// ----------------------------------------------------------------------------
module bmm_dp #(
  parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bmm_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic signed [bmm_pkg::A_W-1:0]    in_a_value,
  input  logic signed [bmm_pkg::B_W-1:0]    in_b_value,
  output logic signed [bmm_pkg::C_W-1:0]    out_c_value,
  output logic                              out_last_of_run,
  input  bmm_pkg::cmd_t                     cmd,
  output bmm_pkg::status_t                  status
);

  import bmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [CFG_W-1:0]        size_r;
  logic [NW-1:0]           n;
  logic [CNT_W-1:0]        total;
  logic [CNT_W-1:0]        cnt_r;
  logic [IW-1:0]           i_r, j_r, k_r;
  logic [CNT_W-1:0]        a_addr_w, b_addr_w;
  logic                    j_last;
  logic [A_W-1:0]          a_rd;
  logic [B_W-1:0]          b_rd;
  logic                    rd_vld_r;
  logic                    prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [C_W-1:0]   acc_r;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Active size, clamped to 1..MAX_DIM
  always_comb begin
    if (size_r == '0) begin
      n = NW'(1);
    end else if (size_r > CFG_W'(MAX_DIM)) begin
      n = NW'(MAX_DIM);
    end else begin
      n = NW'(size_r);
    end
  end

  assign total = CNT_W'(n) * CNT_W'(n);

  // Load counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.run_start) begin
      cnt_r <= '0;
    end else if (cmd.load_wr) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Row, column and term indexes
  assign j_last = (CNT_W'(j_r) + CNT_W'(1)) == CNT_W'(n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else if (cmd.run_start) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.issue) begin
        k_r <= status.k_last ? '0 : k_r + IW'(1);
      end
      if (cmd.next_elem) begin
        if (j_last) begin
          j_r <= '0;
          i_r <= i_r + IW'(1);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
    end
  end

  // Store addresses: A row-major at i*n+k, B at k*n+j
  assign a_addr_w = CNT_W'(i_r) * CNT_W'(n) + CNT_W'(k_r);
  assign b_addr_w = CNT_W'(k_r) * CNT_W'(n) + CNT_W'(j_r);

  // Element stores
  bmm_ram #(
    .WIDTH (A_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_a_value),
    .rd_en   (cmd.issue),
    .rd_addr (a_addr_w[AW-1:0]),
    .rd_data (a_rd)
  );

  bmm_ram #(
    .WIDTH (B_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_b_value),
    .rd_en   (cmd.issue),
    .rd_addr (b_addr_w[AW-1:0]),
    .rd_data (b_rd)
  );

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  // Registered multiply
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= $signed(a_rd) * $signed(b_rd);
    end
  end

  // Accumulator, cleared at the start of each element
  always_ff @(posedge clk) begin
    if (cmd.run_start || cmd.next_elem) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + C_W'(prod_r);
    end
  end

  // Status to controller
  assign status.load_done = (cnt_r + CNT_W'(1)) >= total;
  assign status.k_last    = (CNT_W'(k_r) + CNT_W'(1)) == CNT_W'(n);
  assign status.elem_last = j_last && ((CNT_W'(i_r) + CNT_W'(1)) == CNT_W'(n));

  // Result
  assign out_c_value     = acc_r;
  assign out_last_of_run = status.elem_last;

endmodule

// ===== design/block_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// block_matrix_multiply: square matrix multiplier, C = A*B, n up to MAX_DIM
// Loads A and B element pairs in row-major order, then emits C row-major
// with a flag on its last element.
//
//   channel  ports                                  direction
//   in       in_valid/in_ready, a_value, b_value    load one A/B pair
//   out      out_valid/out_ready, c_value, last     one element of C
//   cfg      cfg_wr_en, cfg_wr_data                 matrix size n
//
// Loading takes one transaction per cycle. The n*n-th pair starts the walk: for each
// element of C the block reads its n A/B terms through one read port per store,
// flushes the read register and the multiplier register, and then holds the result
// on the output channel until out_ready accepts it.
// No input is taken from the final load until the last element of C is accepted.
// Synchronous active-low reset sets size code 8 and load count zero; stores stay.
// ----------------------------------------------------------------------------
module block_matrix_multiply #(
  parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bmm_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [bmm_pkg::A_W-1:0]  in_a_value,
  input  logic signed [bmm_pkg::B_W-1:0]  in_b_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bmm_pkg::C_W-1:0]  out_c_value,
  output logic                            out_last_of_run
);

  import bmm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  bmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Stores, indexes and multiply-accumulate
  bmm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .out_c_value     (out_c_value),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for block_matrix_multiply
// Loads A/B element pairs through the input channel, predicts every element
// of C with a behavioral matrix multiplier, and checks each output
// transaction in order. Covers the reset size, out-of-range size codes, size
// changes partway through a load, field extremes and random traffic, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmm_pkg::*;

  localparam int DIM_MAX       = MAX_DIM_DEF;
  localparam int STORE_DEPTH   = DIM_MAX * DIM_MAX;
  localparam int IDLE_PCT      = 24;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 40;
  localparam int TARGET_PAIRS  = 330;
  localparam int QUIET_FROM    = 1000;
  localparam int QUIET_TO      = 2500;

  typedef enum logic {OP_PAIR, OP_CFG} stim_kind_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_EXTREME, FILL_MAX, FILL_MIN} fill_t;

  typedef struct {
    stim_kind_t            kind;
    logic signed [A_W-1:0] a_val;
    logic signed [B_W-1:0] b_val;
    logic [CFG_W-1:0]      size_code;
  } stim_op_t;

  typedef struct {
    logic signed [C_W-1:0] c_val;
    logic                  run_end;
  } c_elem_t;

  // DUT connections, known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [A_W-1:0] in_a_value = '0;
  logic signed [B_W-1:0] in_b_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [C_W-1:0] out_c_value;
  logic                  out_last_of_run;

  // Stimulus and expected results
  stim_op_t stim_q[$];
  c_elem_t  c_expect_q[$];

  // Behavioral multiplier state
  logic signed [A_W-1:0] a_mem [STORE_DEPTH];
  logic signed [B_W-1:0] b_mem [STORE_DEPTH];
  int                    pairs_loaded = 0;
  logic [CFG_W-1:0]      size_reg = CFG_RESET;

  // Bookkeeping
  int err_cnt      = 0;
  int queued_pairs = 0;
  int pair_cnt     = 0;
  int elem_cnt     = 0;
  int product_cnt  = 0;
  int cfg_cnt      = 0;
  int settle_cnt   = 0;
  int cyc_cnt      = 0;
  logic quiet;

  block_matrix_multiply #(.MAX_DIM(DIM_MAX)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_c_value     (out_c_value),
    .out_last_of_run (out_last_of_run)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle count, drives the stretch with no idling on either side
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
  end
  assign quiet = (cyc_cnt >= QUIET_FROM) && (cyc_cnt < QUIET_TO);

  // Size code to dimension in use: zero means 1, above the maximum clamps
  function automatic int eff_dim(logic [CFG_W-1:0] code);
    if (code == 0) return 1;
    if (code > DIM_MAX) return DIM_MAX;
    return int'(code);
  endfunction

  // Store one pair; on the last pair of a run, compute C and queue it
  function automatic void matmul_load(logic signed [A_W-1:0] a,
                                      logic signed [B_W-1:0] b);
    int      n;
    int      slot;
    longint  acc;
    c_elem_t elem;
    n    = eff_dim(size_reg);
    slot = pairs_loaded % STORE_DEPTH;
    a_mem[slot]  = a;
    b_mem[slot]  = b;
    pairs_loaded = (pairs_loaded + 1) & 8'h7F;
    if (pairs_loaded < n * n) return;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_mem[i*n + k]) * longint'(b_mem[k*n + j]);
        end
        elem.c_val   = acc[C_W-1:0];
        elem.run_end = (i == n - 1) && (j == n - 1);
        c_expect_q.push_back(elem);
      end
    end
    pairs_loaded = 0;
  endfunction

  function automatic logic [A_W-1:0] pick_elem(fill_t mode, bit is_b);
    case (mode)
      FILL_MAX: return 16'h8000;
      FILL_MIN: return is_b ? 16'h7FFF : 16'h8000;
      FILL_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic push_pair(logic [A_W-1:0] a, logic [B_W-1:0] b);
    stim_op_t op;
    op.kind      = OP_PAIR;
    op.a_val     = a;
    op.b_val     = b;
    op.size_code = '0;
    stim_q.push_back(op);
    queued_pairs++;
  endtask

  task automatic push_cfg(logic [CFG_W-1:0] code);
    stim_op_t op;
    op.kind      = OP_CFG;
    op.a_val     = '0;
    op.b_val     = '0;
    op.size_code = code;
    stim_q.push_back(op);
  endtask

  // One run of n*n pairs, less the ones already loaded
  task automatic push_run(int n, fill_t mode, int skip);
    for (int p = skip; p < n * n; p++) begin
      push_pair(pick_elem(mode, 1'b0), pick_elem(mode, 1'b1));
    end
  endtask

  // Driver: one transaction at a time in queue order; size writes wait
  // until the block has drained and settled
  always @(posedge clk) begin : drive_proc
    logic     nxt_valid;
    logic     nxt_cfg;
    stim_op_t op;
    nxt_valid = in_valid && !in_ready;
    nxt_cfg   = 1'b0;
    if (!rst_n) begin
      nxt_valid  = 1'b0;
      settle_cnt = 0;
    end else if (!nxt_valid && stim_q.size() > 0) begin
      if (stim_q[0].kind == OP_CFG) begin
        if (c_expect_q.size() == 0) settle_cnt++;
        else settle_cnt = 0;
        if (settle_cnt >= SETTLE_CYCLES) begin
          op = stim_q.pop_front();
          nxt_cfg     = 1'b1;
          cfg_wr_data <= op.size_code;
          settle_cnt  = 0;
        end
      end else if (quiet || $urandom_range(99) >= IDLE_PCT) begin
        op = stim_q.pop_front();
        nxt_valid  = 1'b1;
        in_a_value <= op.a_val;
        in_b_value <= op.b_val;
      end
    end
    in_valid  <= nxt_valid;
    cfg_wr_en <= nxt_cfg;
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: track size writes, predict on accepted pairs, check results
  always @(posedge clk) begin : check_proc
    c_elem_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
        cfg_cnt++;
      end
      if (in_valid && in_ready) begin
        matmul_load(in_a_value, in_b_value);
        pair_cnt++;
      end
      if (out_valid && out_ready) begin
        elem_cnt++;
        if (out_last_of_run) product_cnt++;
        if (c_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected C element, expected none, actual %0d last %0b",
                   $time, out_c_value, out_last_of_run);
        end else begin
          want = c_expect_q.pop_front();
          if (out_c_value !== want.c_val) begin
            err_cnt++;
            $display("%0t: c_value mismatch, expected %0d, actual %0d",
                     $time, want.c_val, out_c_value);
          end
          if (out_last_of_run !== want.run_end) begin
            err_cnt++;
            $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                     $time, want.run_end, out_last_of_run);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : main_proc
    int          pick;
    int          cur_n;
    int          part;
    logic [3:0]  code;
    fill_t       mode;

    // Full-size run at the reset size, most positive products
    push_run(DIM_MAX, FILL_MAX, 0);

    // 1x1 products at the field extremes
    push_cfg(4'd1);
    push_pair(16'h8000, 16'h8000);
    push_pair(16'h7FFF, 16'h8000);
    push_pair(16'h0000, 16'h0000);
    // size code zero acts as 1
    push_cfg(4'd0);
    push_pair(16'hFFFF, 16'hFFFF);
    // 2x2, both matrices at the most negative value
    push_cfg(4'd2);
    push_run(2, FILL_MAX, 0);
    // shrink partway through a load: the next pair completes the run
    push_cfg(4'd3);
    push_run(2, FILL_EXTREME, -1);
    push_cfg(4'd2);
    push_pair(16'h1234, 16'hFEDC);
    // grow partway through a load
    push_cfg(4'd2);
    push_run(2, FILL_RANDOM, 2);
    push_cfg(4'd3);
    push_run(3, FILL_RANDOM, 2);

    // Random phases, mostly small sizes; room is left for the closing run
    while (queued_pairs < TARGET_PAIRS - STORE_DEPTH) begin
      pick = $urandom_range(99);
      if (pick < 10) code = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
      else if (pick < 25) code = 4'($urandom_range(5, 8));
      else code = 4'($urandom_range(1, 4));
      push_cfg(code);
      cur_n = eff_dim(code);
      repeat ($urandom_range(1, 3)) begin
        if (cur_n > 1 && $urandom_range(99) < 15) begin
          // broken run: the size moves partway through the load
          part = $urandom_range(1, cur_n * cur_n - 1);
          push_run(cur_n, FILL_RANDOM, cur_n * cur_n - part);
          code = ($urandom_range(99) < 20) ? 4'($urandom_range(15))
                                           : 4'($urandom_range(1, 4));
          push_cfg(code);
          cur_n = eff_dim(code);
          push_run(cur_n, FILL_RANDOM,
                   (part < cur_n * cur_n) ? part : cur_n * cur_n - 1);
        end else begin
          pick = $urandom_range(99);
          if (pick < 60) mode = FILL_RANDOM;
          else if (pick < 80) mode = FILL_EXTREME;
          else if (pick < 90) mode = FILL_MAX;
          else mode = FILL_MIN;
          push_run(cur_n, mode, 0);
        end
      end
    end
    // close with a full-size run of most negative products
    push_cfg(4'd8);
    push_run(DIM_MAX, FILL_MIN, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() > 0 || in_valid || cfg_wr_en) @(posedge clk);
    while (c_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d A/B pairs over %0d size writes", pair_cnt, cfg_cnt);
    $display("Checked %0d elements of C across %0d products", elem_cnt, product_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
